@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. They compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`else

`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/lsrb_pkg.sv @@
`default_nettype none

package lsrb_pkg;

    localparam int INTERVAL_W = 10;
    localparam int SKIP_W     = 8;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 16;
    localparam int HZ_W       = 8;
    localparam int RATE_W     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Divider: dividend holds up to 65535 * 1000, divisor a full time difference.
    localparam int DIV_W     = 26;
    localparam int DEN_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int MS_PER_S = 1000;
    localparam int RATE_MIN = 10;
    localparam int RATE_MAX = 200;
    localparam int HZ_SAT   = 255;

    localparam logic [INTERVAL_W-1:0] DEFAULT_INTERVAL_RST = INTERVAL_W'(10);
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST     = INTERVAL_W'(5);
    localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RST     = INTERVAL_W'(100);
    localparam logic [INTERVAL_W-1:0] BACKOFF_STEP_RST     = INTERVAL_W'(5);
    localparam logic [INTERVAL_W-1:0] CEILING_RST          = INTERVAL_W'(50);
    localparam logic [SKIP_W-1:0]     SKIPS_RST            = SKIP_W'(8);
    localparam logic [CNT_W-1:0]      RECOVER_RST          = CNT_W'(2000);
    localparam logic [CNT_W-1:0]      STAT_INTERVAL_RST    = CNT_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT_INTERVAL = 3'd0,
        REG_MIN_INTERVAL     = 3'd1,
        REG_MAX_INTERVAL     = 3'd2,
        REG_BACKOFF_STEP     = 3'd3,
        REG_CEILING          = 3'd4,
        REG_SKIPS            = 3'd5,
        REG_RECOVER          = 3'd6,
        REG_STAT_INTERVAL    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] min_interval;
        logic [INTERVAL_W-1:0] max_interval;
        logic [INTERVAL_W-1:0] backoff_step;
        logic [INTERVAL_W-1:0] ceiling;
        logic [SKIP_W-1:0]     skips;
        logic [CNT_W-1:0]      recover;
        logic [CNT_W-1:0]      stat_interval;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

@@ hdl/link_send_rate_backoff.sv @@
// A frame attempt without a divide steps through FRAME and REPORT to FINISH;
// a frame attempt that reports after a nonzero elapsed time, and a set-rate command,
// also wait for the shared divider. Items are handled one at a time: a new item is
// accepted the cycle after the result is loaded into the output register; a result
// still waiting there stalls the next one.
// Reset: aresetn is synchronous, active low; all counters clear, both intervals load 10 ms.
`default_nettype none

`include "assert_macros.svh"

module link_send_rate_backoff (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input item channel.
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic [lsrb_pkg::TIME_W-1:0]       s_now_ms,
    input  wire logic                              s_link_ready,
    input  wire logic [lsrb_pkg::RATE_W-1:0]       s_rate_hz,
    // Result item channel.
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_sent,
    output logic      [lsrb_pkg::CNT_W-1:0]        m_seq,
    output logic                                   m_stat_valid,
    output logic      [lsrb_pkg::HZ_W-1:0]         m_tx_hz,
    output logic      [lsrb_pkg::CNT_W-1:0]        m_dropped_count,
    output logic      [lsrb_pkg::INTERVAL_W-1:0]   m_interval_ms,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [lsrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lsrb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // The sequencer walks each item through a few short steps. A frame attempt
    // first updates the drop, skip and interval state, then checks whether a
    // statistics report is due. A report with a nonzero elapsed time runs the
    // divider for the sent rate; a set-rate command uses the same divider for
    // 1000 / rate. Every path ends in FINISH, which loads the output register.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAME,
        ST_REPORT,
        ST_RPT_DIV,
        ST_RATE,
        ST_RATE_DIV,
        ST_FINISH
    } state_t;

    lsrb_pkg::cfg_t      cfg;
    lsrb_pkg::div_stat_t div_stat;
    logic [lsrb_pkg::DIV_W-1:0] div_quo;
    logic                       div_start;
    logic [lsrb_pkg::DIV_W-1:0] div_dividend;
    logic [lsrb_pkg::DEN_W-1:0] div_divisor;

    state_t state_reg, state_next;

    // Captured input item.
    logic [lsrb_pkg::TIME_W-1:0] now_reg, now_next;
    logic                        link_reg, link_next;
    logic [lsrb_pkg::RATE_W-1:0] rate_reg, rate_next;

    // Block state.
    logic [lsrb_pkg::INTERVAL_W-1:0] base_reg, base_next;
    logic [lsrb_pkg::INTERVAL_W-1:0] cur_reg, cur_next;
    logic [lsrb_pkg::SKIP_W-1:0]     skip_reg, skip_next;
    logic [lsrb_pkg::TIME_W-1:0]     clean_reg, clean_next;
    logic [lsrb_pkg::CNT_W-1:0]      since_reg, since_next;
    logic [lsrb_pkg::HZ_W-1:0]       hz_reg, hz_next;
    logic [lsrb_pkg::TIME_W-1:0]     rpt_time_reg, rpt_time_next;
    logic [lsrb_pkg::CNT_W-1:0]      drop_reg, drop_next;
    logic [lsrb_pkg::CNT_W-1:0]      next_seq_reg, next_seq_next;
    logic                            armed_reg, armed_next;

    // Per-item result flags.
    logic                       res_sent_reg, res_sent_next;
    logic [lsrb_pkg::CNT_W-1:0] res_seq_reg, res_seq_next;
    logic                       res_stat_reg, res_stat_next;

    // Output register.
    logic                            m_valid_reg, m_valid_next;
    logic                            m_sent_reg, m_sent_next;
    logic [lsrb_pkg::CNT_W-1:0]      m_seq_reg, m_seq_next;
    logic                            m_stat_reg, m_stat_next;
    logic [lsrb_pkg::HZ_W-1:0]       m_hz_reg, m_hz_next;
    logic [lsrb_pkg::CNT_W-1:0]      m_drop_reg, m_drop_next;
    logic [lsrb_pkg::INTERVAL_W-1:0] m_int_reg, m_int_next;

    // Scratch values for the sequencer.
    logic [lsrb_pkg::SKIP_W-1:0]     skip_inc;
    logic [lsrb_pkg::INTERVAL_W:0]   backed_off;
    logic [lsrb_pkg::INTERVAL_W:0]   base_plus_step;
    logic [lsrb_pkg::TIME_W-1:0]     clean_elapsed;
    logic [lsrb_pkg::TIME_W-1:0]     rpt_elapsed;
    logic [lsrb_pkg::RATE_W-1:0]     rate_clamped;
    logic [lsrb_pkg::DIV_W-1:0]      ms_lo;
    logic [lsrb_pkg::DIV_W-1:0]      ms_hi;

    lsrb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lsrb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        link_next     = link_reg;
        rate_next     = rate_reg;
        base_next     = base_reg;
        cur_next      = cur_reg;
        skip_next     = skip_reg;
        clean_next    = clean_reg;
        since_next    = since_reg;
        hz_next       = hz_reg;
        rpt_time_next = rpt_time_reg;
        drop_next     = drop_reg;
        next_seq_next = next_seq_reg;
        armed_next    = armed_reg;
        res_sent_next = res_sent_reg;
        res_seq_next  = res_seq_reg;
        res_stat_next = res_stat_reg;
        m_sent_next   = m_sent_reg;
        m_seq_next    = m_seq_reg;
        m_stat_next   = m_stat_reg;
        m_hz_next     = m_hz_reg;
        m_drop_next   = m_drop_reg;
        m_int_next    = m_int_reg;
        // The consumer may take the waiting result at any time.
        m_valid_next  = m_valid_reg && !m_ready;

        skip_inc       = (skip_reg == lsrb_pkg::SKIP_W'(lsrb_pkg::HZ_SAT)) ?
                         skip_reg : skip_reg + 1'b1;
        backed_off     = {1'b0, cur_reg} + {1'b0, cfg.backoff_step};
        base_plus_step = {1'b0, base_reg} + {1'b0, cfg.backoff_step};
        clean_elapsed  = now_reg - clean_reg;
        rpt_elapsed    = now_reg - rpt_time_reg;

        div_start    = 1'b0;
        div_dividend = lsrb_pkg::DIV_W'(since_reg) * lsrb_pkg::DIV_W'(lsrb_pkg::MS_PER_S);
        div_divisor  = rpt_elapsed;

        // The requested rate is held to 10..200 Hz before dividing.
        if (rate_reg < lsrb_pkg::RATE_W'(lsrb_pkg::RATE_MIN)) begin
            rate_clamped = lsrb_pkg::RATE_W'(lsrb_pkg::RATE_MIN);
        end else if (rate_reg > lsrb_pkg::RATE_W'(lsrb_pkg::RATE_MAX)) begin
            rate_clamped = lsrb_pkg::RATE_W'(lsrb_pkg::RATE_MAX);
        end else begin
            rate_clamped = rate_reg;
        end

        // The min limit applies first, so the max limit wins when they cross.
        ms_lo = (div_quo < lsrb_pkg::DIV_W'(cfg.min_interval)) ?
                lsrb_pkg::DIV_W'(cfg.min_interval) : div_quo;
        ms_hi = (ms_lo > lsrb_pkg::DIV_W'(cfg.max_interval)) ?
                lsrb_pkg::DIV_W'(cfg.max_interval) : ms_lo;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next      = s_now_ms;
                    link_next     = s_link_ready;
                    rate_next     = s_rate_hz;
                    res_sent_next = 1'b0;
                    res_seq_next  = '0;
                    res_stat_next = 1'b0;
                    state_next    = s_op ? ST_RATE : ST_FRAME;
                end
            end

            ST_FRAME: begin
                // The first frame attempt starts the report window.
                if (!armed_reg) begin
                    armed_next    = 1'b1;
                    rpt_time_next = now_reg;
                end
                if (!link_reg) begin
                    drop_next = drop_reg + 1'b1;
                    if (skip_inc >= cfg.skips && cur_reg < cfg.ceiling) begin
                        // Persistent congestion: back off one step, capped by the ceiling.
                        cur_next   = (backed_off > {1'b0, cfg.ceiling}) ?
                                     cfg.ceiling : backed_off[lsrb_pkg::INTERVAL_W-1:0];
                        skip_next  = '0;
                        clean_next = now_reg;
                    end else begin
                        skip_next = skip_inc;
                    end
                end else begin
                    res_sent_next = 1'b1;
                    res_seq_next  = next_seq_reg;
                    next_seq_next = next_seq_reg + 1'b1;
                    since_next    = since_reg + 1'b1;
                    if (skip_reg != '0) begin
                        skip_next = skip_reg - 1'b1;
                    end
                    if (cur_reg > base_reg &&
                        clean_elapsed >= lsrb_pkg::TIME_W'(cfg.recover)) begin
                        // A clean stretch steps the interval down, never below base.
                        if ({1'b0, cur_reg} > base_plus_step) begin
                            cur_next = cur_reg - cfg.backoff_step;
                        end else begin
                            cur_next = base_reg;
                        end
                        clean_next = now_reg;
                    end else if (cur_reg <= base_reg) begin
                        clean_next = now_reg;
                    end
                end
                state_next = ST_REPORT;
            end

            ST_REPORT: begin
                if (rpt_elapsed >= lsrb_pkg::TIME_W'(cfg.stat_interval)) begin
                    res_stat_next = 1'b1;
                    since_next    = '0;
                    rpt_time_next = now_reg;
                    // With no time gone by the last rate stands.
                    if (rpt_elapsed != '0) begin
                        div_start  = 1'b1;
                        state_next = ST_RPT_DIV;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end

            ST_RPT_DIV: begin
                if (div_stat.done) begin
                    hz_next    = (div_quo > lsrb_pkg::DIV_W'(lsrb_pkg::HZ_SAT)) ?
                                 lsrb_pkg::HZ_W'(lsrb_pkg::HZ_SAT) :
                                 div_quo[lsrb_pkg::HZ_W-1:0];
                    state_next = ST_FINISH;
                end
            end

            ST_RATE: begin
                div_start    = 1'b1;
                div_dividend = lsrb_pkg::DIV_W'(lsrb_pkg::MS_PER_S);
                div_divisor  = lsrb_pkg::DEN_W'(rate_clamped);
                skip_next    = '0;
                state_next   = ST_RATE_DIV;
            end

            ST_RATE_DIV: begin
                if (div_stat.done) begin
                    base_next  = ms_hi[lsrb_pkg::INTERVAL_W-1:0];
                    cur_next   = ms_hi[lsrb_pkg::INTERVAL_W-1:0];
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sent_next  = res_sent_reg;
                    m_seq_next   = res_seq_reg;
                    m_stat_next  = res_stat_reg;
                    m_hz_next    = hz_reg;
                    m_drop_next  = drop_reg;
                    m_int_next   = cur_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            base_reg     <= lsrb_pkg::DEFAULT_INTERVAL_RST;
            cur_reg      <= lsrb_pkg::DEFAULT_INTERVAL_RST;
            skip_reg     <= '0;
            clean_reg    <= '0;
            since_reg    <= '0;
            hz_reg       <= '0;
            rpt_time_reg <= '0;
            drop_reg     <= '0;
            next_seq_reg <= '0;
            armed_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            cur_reg      <= cur_next;
            skip_reg     <= skip_next;
            clean_reg    <= clean_next;
            since_reg    <= since_next;
            hz_reg       <= hz_next;
            rpt_time_reg <= rpt_time_next;
            drop_reg     <= drop_next;
            next_seq_reg <= next_seq_next;
            armed_reg    <= armed_next;
            m_valid_reg  <= m_valid_next;
        end
        now_reg      <= now_next;
        link_reg     <= link_next;
        rate_reg     <= rate_next;
        res_sent_reg <= res_sent_next;
        res_seq_reg  <= res_seq_next;
        res_stat_reg <= res_stat_next;
        m_sent_reg   <= m_sent_next;
        m_seq_reg    <= m_seq_next;
        m_stat_reg   <= m_stat_next;
        m_hz_reg     <= m_hz_next;
        m_drop_reg   <= m_drop_next;
        m_int_reg    <= m_int_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_sent          = m_sent_reg;
    assign m_seq           = m_seq_reg;
    assign m_stat_valid    = m_stat_reg;
    assign m_tx_hz         = m_hz_reg;
    assign m_dropped_count = m_drop_reg;
    assign m_interval_ms   = m_int_reg;

    // The divider is idle whenever a new item can be taken.
    `ASSERT_IMPL(a_ready_div_idle, aclk, aresetn, s_ready, !div_stat.busy)
    // An accepted item keeps the block busy for at least the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A result without a sent frame carries sequence number zero.
    `ASSERT_IMPL(a_unsent_seq_zero, aclk, aresetn, m_valid && !m_sent, m_seq == '0)

endmodule

`default_nettype wire

@@ hdl/lsrb_cfg.sv @@
`default_nettype none

// Configuration register file. The default interval only matters at reset,
// where the block uses its reset value, so a write to it is not stored.
module lsrb_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [lsrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsrb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output lsrb_pkg::cfg_t                       cfg
);

    lsrb_pkg::cfg_t cfg_reg;
    lsrb_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (lsrb_pkg::cfg_index_t'(cfg_index))
                lsrb_pkg::REG_DEFAULT_INTERVAL: cfg_next = cfg_reg;
                lsrb_pkg::REG_MIN_INTERVAL:
                    cfg_next.min_interval = cfg_wdata[lsrb_pkg::INTERVAL_W-1:0];
                lsrb_pkg::REG_MAX_INTERVAL:
                    cfg_next.max_interval = cfg_wdata[lsrb_pkg::INTERVAL_W-1:0];
                lsrb_pkg::REG_BACKOFF_STEP:
                    cfg_next.backoff_step = cfg_wdata[lsrb_pkg::INTERVAL_W-1:0];
                lsrb_pkg::REG_CEILING:
                    cfg_next.ceiling = cfg_wdata[lsrb_pkg::INTERVAL_W-1:0];
                lsrb_pkg::REG_SKIPS:
                    cfg_next.skips = cfg_wdata[lsrb_pkg::SKIP_W-1:0];
                lsrb_pkg::REG_RECOVER:
                    cfg_next.recover = cfg_wdata[lsrb_pkg::CNT_W-1:0];
                lsrb_pkg::REG_STAT_INTERVAL:
                    cfg_next.stat_interval = cfg_wdata[lsrb_pkg::CNT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_interval  <= lsrb_pkg::MIN_INTERVAL_RST;
            cfg_reg.max_interval  <= lsrb_pkg::MAX_INTERVAL_RST;
            cfg_reg.backoff_step  <= lsrb_pkg::BACKOFF_STEP_RST;
            cfg_reg.ceiling       <= lsrb_pkg::CEILING_RST;
            cfg_reg.skips         <= lsrb_pkg::SKIPS_RST;
            cfg_reg.recover       <= lsrb_pkg::RECOVER_RST;
            cfg_reg.stat_interval <= lsrb_pkg::STAT_INTERVAL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/lsrb_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient holds after done.
module lsrb_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [lsrb_pkg::DIV_W-1:0] dividend,
    input  wire logic [lsrb_pkg::DEN_W-1:0] divisor,
    output lsrb_pkg::div_stat_t             stat,
    output logic      [lsrb_pkg::DIV_W-1:0] quotient
);

    logic [lsrb_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [lsrb_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [lsrb_pkg::DEN_W-1:0]     den_reg, den_next;
    logic [lsrb_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [lsrb_pkg::DEN_W:0]       shifted;
    logic [lsrb_pkg::DEN_W:0]       trial;

    always_comb begin
        shifted   = {rem_reg, quo_reg[lsrb_pkg::DIV_W-1]};
        trial     = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
            cnt_next = lsrb_pkg::DIV_CNT_W'(lsrb_pkg::DIV_W);
        end else if (cnt_reg != '0) begin
            if (!trial[lsrb_pkg::DEN_W]) begin
                rem_next = trial[lsrb_pkg::DEN_W-1:0];
                quo_next = {quo_reg[lsrb_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[lsrb_pkg::DEN_W-1:0];
                quo_next = {quo_reg[lsrb_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == lsrb_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire
